// ----- rtl/interval_range_map_macros.svh -----
// Assertion helpers for the interval range map
`ifndef INTERVAL_RANGE_MAP_MACROS_SVH
`define INTERVAL_RANGE_MAP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define IRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define IRM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/irm_pkg.sv -----
package irm_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 8;

  localparam logic       REQ_ASSIGN = 1'b0;
  localparam logic       REQ_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                             req_type;
    logic signed [KEY_BITS_DEF-1:0]   begin_key;
    logic signed [KEY_BITS_DEF-1:0]   end_key;
    logic        [VALUE_BITS_DEF-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS_DEF-1:0] read_value;
    logic [1:0]                status;
  } out_item_t;

endpackage

// ----- rtl/interval_range_map.sv -----
// Interval range map. Holds up to CAPACITY boundary keys (signed), each
// starting a run of one value; keys below the first boundary read the
// default_value register. An assign paints new_value over [begin_key,
// end_key) and keeps the table canonical; a lookup returns one key's value.
// Every request returns one result transfer with a status (done, empty
// interval ignored, table full refused). The block works on one request at
// a time: a shared compare unit scans the key memory one entry a cycle to
// find the two split points, and an assign then rewrites the tail of the
// table one entry a cycle through a second memory bank. The key and value
// stores start undefined; only the first N entries, N being the boundary
// count, are ever read. in_stall is high whenever a request is in work or
// a result waits.
module interval_range_map #(
  parameter int CAPACITY = irm_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  irm_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output irm_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [irm_pkg::VALUE_BITS_DEF-1:0] cfg_wdata
);

  localparam int KB = irm_pkg::KEY_BITS_DEF;
  localparam int VB = irm_pkg::VALUE_BITS_DEF;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_BACK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Main table and a scratch bank for rebuilding the tail
  logic [KB-1:0] key_mem [CAPACITY];
  logic [VB-1:0] val_mem [CAPACITY];
  logic [KB-1:0] tkey_mem [CAPACITY];
  logic [VB-1:0] tval_mem [CAPACITY];

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [VB-1:0] dflt_r;
  logic          lookup_r;
  logic [KB-1:0] bkey_r, ekey_r;
  logic [VB-1:0] nval_r;
  logic [CW-1:0] idx_r;     // scan / copy index
  logic          rd_ok_r;   // read data for idx_r-1 is present
  logic [KB-1:0] rkey_r;
  logic [VB-1:0] rval_r;
  logic [CW-1:0] lo_r, hi_r;
  logic [VB-1:0] before_r, atend_r;
  logic [CW-1:0] wr_r;      // write pointer in main table
  logic [CW-1:0] tn_r;      // scratch fill
  logic          put_b_r, put_e_r;
  logic [CW-1:0] rd_idx;    // index of the entry whose data sits in rkey_r
  logic [1:0]    pend_r;    // head inserts still to write: bit0 begin, bit1 end
  irm_pkg::out_item_t res_r;
  logic          ovalid_r;

  // Hold the input while busy or while a result waits for its transfer
  assign in_stall  = (state_r != S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = res_r;
  assign rd_idx    = idx_r - CW'(1);

  // Scratch bank: copy entries hi..count-1, then write back after the inserts
  logic [AW-1:0] tr_addr;
  logic [KB-1:0] tr_key;
  logic [VB-1:0] tr_val;
  assign tr_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    rkey_r <= key_mem[idx_r[AW-1:0]];
    rval_r <= val_mem[idx_r[AW-1:0]];
    tr_key <= tkey_mem[tr_addr];
    tr_val <= tval_mem[tr_addr];
  end

  logic          kw_en, tw_en;
  logic [AW-1:0] kw_addr, tw_addr;
  logic [KB-1:0] kw_key;
  logic [VB-1:0] kw_val;

  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_key;
      val_mem[kw_addr] <= kw_val;
    end
    if (tw_en) begin
      tkey_mem[tw_addr] <= rkey_r;
      tval_mem[tw_addr] <= rval_r;
    end
  end

  // Order-mapped keys: flip the sign bit so unsigned compare orders them
  logic [KB-1:0] ordb, orde, ordr;
  assign ordb = bkey_r ^ {1'b1, {(KB-1){1'b0}}};
  assign orde = ekey_r ^ {1'b1, {(KB-1){1'b0}}};
  assign ordr = rkey_r ^ {1'b1, {(KB-1){1'b0}}};

  // Empty interval on the offered request: answer at once
  logic req_empty;
  assign req_empty = in_data.req_type == irm_pkg::REQ_ASSIGN &&
                     !((in_data.begin_key ^ {1'b1, {(KB-1){1'b0}}}) <
                       (in_data.end_key ^ {1'b1, {(KB-1){1'b0}}}));

  logic [CW:0] new_cnt;
  assign new_cnt = {1'b0, count_r} - {1'b0, hi_r} + {1'b0, lo_r}
                   + (CW+1)'(put_b_r) + (CW+1)'(put_e_r);

  logic [VB-1:0] before_w, atend_w;
  logic          pb_w, pe_w;
  assign before_w = before_r;
  assign atend_w  = atend_r;
  assign pb_w     = (nval_r != before_w);
  assign pe_w     = (atend_w != nval_r);

  // Refuse the assign when the rebuilt table would not fit
  logic full_w;
  assign full_w = ({1'b0, count_r} - {1'b0, hi_r} + {1'b0, lo_r}
                   + (CW+1)'(pb_w) + (CW+1)'(pe_w)) > {1'b0, CAP_C};

  always_comb begin
    state_nxt = state_r;
    kw_en = 1'b0; kw_addr = wr_r[AW-1:0]; kw_key = '0; kw_val = '0;
    tw_en = 1'b0; tw_addr = tn_r[AW-1:0];
    unique case (state_r)
      S_IDLE: if (in_valid && !ovalid_r && !req_empty) state_nxt = S_SCAN;
      S_SCAN: if (rd_ok_r && rd_idx + CW'(1) >= count_r || count_r == '0)
                state_nxt = lookup_r ? S_OUT : S_DEC;
      S_DEC:  state_nxt = full_w ? S_OUT : S_COPY;
      S_COPY: begin
        if (rd_ok_r && rd_idx < count_r) begin
          tw_en = 1'b1;
        end
        if (!rd_ok_r || rd_idx + CW'(1) >= count_r) begin
          if (hi_r >= count_r) state_nxt = S_BACK;
          else if (rd_ok_r) state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        if (pend_r[0]) begin
          kw_en = 1'b1; kw_key = bkey_r; kw_val = nval_r;
        end else if (pend_r[1]) begin
          kw_en = 1'b1; kw_key = ekey_r; kw_val = atend_r;
        end else if (rd_ok_r && idx_r <= tn_r) begin
          kw_en = 1'b1; kw_key = tr_key; kw_val = tr_val;
        end
        if (pend_r == 2'b00 && rd_ok_r && idx_r >= tn_r) state_nxt = S_OUT;
        if (pend_r == 2'b00 && tn_r == '0) state_nxt = S_OUT;
      end
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      dflt_r   <= '0;
      ovalid_r <= 1'b0;
      rd_ok_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) dflt_r <= cfg_wdata;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !ovalid_r) begin
            lookup_r <= in_data.req_type == irm_pkg::REQ_LOOKUP;
            bkey_r   <= in_data.begin_key;
            ekey_r   <= in_data.end_key;
            nval_r   <= in_data.new_value;
            idx_r    <= '0;
            rd_ok_r  <= 1'b0;
            lo_r     <= '0;
            hi_r     <= '0;
            before_r <= dflt_r;
            atend_r  <= dflt_r;
            if (req_empty) begin
              res_r    <= '{read_value: '0, status: irm_pkg::ST_EMPTY};
              ovalid_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // Shared compare: one stored boundary a cycle
          if (idx_r < count_r) idx_r <= idx_r + CW'(1);
          rd_ok_r <= idx_r < count_r;
          if (rd_ok_r) begin
            if (ordr < ordb) begin
              lo_r <= rd_idx + CW'(1); before_r <= rval_r;
            end
            if (ordr <= orde && !lookup_r || lookup_r && ordr <= ordb) begin
              hi_r <= rd_idx + CW'(1); atend_r <= rval_r;
            end
          end
          if (state_nxt == S_OUT) begin
            res_r <= '{read_value: (rd_ok_r && ordr <= ordb) ? rval_r : atend_r,
                       status: irm_pkg::ST_DONE};
          end
        end
        S_DEC: begin
          put_b_r <= pb_w;
          put_e_r <= pe_w;
          if (full_w) begin
            res_r <= '{read_value: '0, status: irm_pkg::ST_FULL};
          end
          idx_r   <= hi_r;
          rd_ok_r <= 1'b0;
          tn_r    <= '0;
        end
        S_COPY: begin
          if (tw_en) tn_r <= tn_r + CW'(1);
          if (state_nxt == S_BACK) begin
            idx_r   <= '0;
            rd_ok_r <= 1'b0;
            wr_r    <= lo_r;
            pend_r  <= {put_e_r, put_b_r};
          end else begin
            if (idx_r < count_r) idx_r <= idx_r + CW'(1);
            rd_ok_r <= idx_r < count_r;
          end
        end
        S_BACK: begin
          if (kw_en) wr_r <= wr_r + CW'(1);
          if (pend_r[0]) pend_r[0] <= 1'b0;
          else if (pend_r[1]) pend_r[1] <= 1'b0;
          else begin
            if (idx_r < tn_r) idx_r <= idx_r + CW'(1);
            rd_ok_r <= idx_r < tn_r;
          end
          if (state_nxt == S_OUT) begin
            count_r <= new_cnt[CW-1:0];
            res_r   <= '{read_value: '0, status: irm_pkg::ST_DONE};
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `include "interval_range_map_macros.svh"

  `IRM_ASSERT(a_cnt_cap, count_r <= CAP_C, "boundary count beyond capacity")
  `IRM_ASSERT(a_stat_ok, !ovalid_r || res_r.status == irm_pkg::ST_DONE || res_r.status == irm_pkg::ST_EMPTY || res_r.status == irm_pkg::ST_FULL, "bad status code")
  `IRM_ASSERT(a_busy, (state_r != S_IDLE) |-> in_stall, "accepted while busy")

endmodule

// ----- bench/interval_range_map_tb.sv -----
`timescale 1ns / 1ps

module interval_range_map_tb;

  localparam int KB           = irm_pkg::KEY_BITS_DEF;
  localparam int VB           = irm_pkg::VALUE_BITS_DEF;
  localparam int CAP          = irm_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1500000;
  // Settle time before reconfiguring, longer than the worst assign takes.
  localparam int SETTLE       = 4 * CAP + 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  irm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  irm_pkg::out_item_t out_data;
  logic               cfg_we = 1'b0;
  logic [VB-1:0]      cfg_wdata = '0;

  interval_range_map DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the boundary table, keys held as signed values.
  logic signed [KB-1:0] shadow_keys [CAP];
  logic [VB-1:0]        shadow_vals [CAP];
  int                   shadow_count;
  logic [VB-1:0]        shadow_default;

  irm_pkg::out_item_t pending_results [$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        result_count = 0;
  int        full_count = 0;
  int        empty_count = 0;
  int        lookup_count = 0;

  // Receiver behaviour: 0 random idling, 1 none, 2 long hold-off.
  int  sink_mode = 0;
  int  sink_hold = 0;
  // Sender idling switch, off during the quiet stretch.
  bit  src_idle_on = 1'b1;

  // Count boundaries below k, or at most k when inclusive.
  function automatic int boundaries_before(logic signed [KB-1:0] k,
                                           bit inclusive);
    int n;
    n = 0;
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] < k || (inclusive && shadow_keys[i] == k)) n = i + 1;
    return n;
  endfunction

  // Work out the result of one request and update the shadow table.
  function automatic irm_pkg::out_item_t apply_request(irm_pkg::in_item_t req);
    irm_pkg::out_item_t r;
    int lo, hi, n;
    logic [VB-1:0] prev_val, end_val;
    bit put_b, put_e;
    logic signed [KB-1:0] nk [CAP];
    logic [VB-1:0]        nv [CAP];
    r = '0;
    if (req.req_type == irm_pkg::REQ_LOOKUP) begin
      n = boundaries_before(req.begin_key, 1'b1);
      r.read_value = n ? shadow_vals[n-1] : shadow_default;
      r.status = irm_pkg::ST_DONE;
      return r;
    end
    if (!(req.begin_key < req.end_key)) begin
      r.status = irm_pkg::ST_EMPTY;
      return r;
    end
    lo = boundaries_before(req.begin_key, 1'b0);
    hi = boundaries_before(req.end_key, 1'b1);
    prev_val = lo ? shadow_vals[lo-1] : shadow_default;
    end_val  = hi ? shadow_vals[hi-1] : shadow_default;
    put_b = (req.new_value != prev_val);
    put_e = (end_val != req.new_value);
    if (shadow_count - (hi - lo) + put_b + put_e > CAP) begin
      r.status = irm_pkg::ST_FULL;
      return r;
    end
    n = 0;
    for (int i = 0; i < lo; i++) begin
      nk[n] = shadow_keys[i]; nv[n] = shadow_vals[i]; n++;
    end
    if (put_b) begin
      nk[n] = req.begin_key; nv[n] = req.new_value; n++;
    end
    if (put_e) begin
      nk[n] = req.end_key; nv[n] = end_val; n++;
    end
    for (int i = hi; i < shadow_count; i++) begin
      nk[n] = shadow_keys[i]; nv[n] = shadow_vals[i]; n++;
    end
    for (int i = 0; i < n; i++) begin
      shadow_keys[i] = nk[i]; shadow_vals[i] = nv[i];
    end
    shadow_count = n;
    r.status = irm_pkg::ST_DONE;
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: drive stall, check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    irm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %0d status %0d",
               out_data.read_value, out_data.status);
        error_count <= error_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, out_data.read_value);
          error_count <= error_count + 1;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          error_count <= error_count + 1;
        end
      end
    end
    // Choose the stall for the next edge.
    if (sink_mode == 2) begin
      out_stall <= 1'b1;
      sink_hold <= sink_hold + 1;
    end else if (sink_mode == 1) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 22);
    end
  end

  // Offer one request and wait for its transfer; predict on acceptance.
  task automatic send_request(irm_pkg::in_item_t req);
    irm_pkg::out_item_t predicted;
    // Let the drop of valid from the previous transfer take effect first.
    if (in_valid) @(posedge clk);
    while (src_idle_on && $urandom_range(99) < 22) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(req);
    pending_results.push_back(predicted);
    if (req.req_type == irm_pkg::REQ_LOOKUP) lookup_count++;
    else if (predicted.status == irm_pkg::ST_FULL) full_count++;
    else if (predicted.status == irm_pkg::ST_EMPTY) empty_count++;
    in_valid <= 1'b0;
  endtask

  // Send a request whose result is known by eye and check the prediction against it.
  task automatic send_known(irm_pkg::in_item_t req, irm_pkg::out_item_t known);
    irm_pkg::out_item_t last;
    send_request(req);
    last = pending_results[$];
    if (last !== known) begin
      $error("directed row: expected read_value %0d status %0d, predicted %0d %0d",
             known.read_value, known.status, last.read_value, last.status);
      error_count++;
    end
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_default(logic [VB-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_default = v;
  endtask

  function automatic irm_pkg::in_item_t make_req(logic t, int b, int e, int v);
    irm_pkg::in_item_t r;
    r.req_type  = t;
    r.begin_key = b;
    r.end_key   = e;
    r.new_value = VB'(v);
    return r;
  endfunction

  // Random key: mostly from a narrow window so intervals overlap, sometimes anywhere.
  function automatic logic signed [KB-1:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(400)) - 200;
    endcase
  endfunction

  function automatic irm_pkg::in_item_t random_req();
    irm_pkg::in_item_t r;
    r.req_type  = ($urandom_range(99) < 35) ? irm_pkg::REQ_LOOKUP : irm_pkg::REQ_ASSIGN;
    r.begin_key = pick_key();
    r.end_key   = ($urandom_range(9) == 0) ? pick_key()
                                           : r.begin_key + $signed($urandom_range(40));
    // Wide values most of the time keep runs distinct and fill the table.
    r.new_value = VB'(($urandom_range(3) == 0) ? $urandom_range(3) : $urandom());
    return r;
  endfunction

  typedef struct {
    irm_pkg::in_item_t  req;
    bit                 known;
    irm_pkg::out_item_t result;
  } stim_row_t;

  stim_row_t directed_rows [$];

  initial begin
    irm_pkg::in_item_t  req;
    irm_pkg::out_item_t ok, empty, full;
    shadow_count   = 0;
    shadow_default = '0;
    ok = '0;                    ok.status = irm_pkg::ST_DONE;
    empty = '0;                 empty.status = irm_pkg::ST_EMPTY;
    full = '0;                  full.status = irm_pkg::ST_FULL;

    // Directed table: reset state, extremes, empty intervals, overlaps.
    directed_rows = '{
      '{make_req(irm_pkg::REQ_LOOKUP, 0, 0, 0), 1, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 32'sh80000000, 0, 8'hff), 1, ok},
      '{make_req(irm_pkg::REQ_ASSIGN, 5, 5, 8'h11), 1, empty},
      '{make_req(irm_pkg::REQ_ASSIGN, 9, 3, 8'h11), 1, empty},
      '{make_req(irm_pkg::REQ_ASSIGN, 32'sh7fffffff, 32'sh80000000, 1), 1, empty},
      '{make_req(irm_pkg::REQ_ASSIGN, 10, 20, 0), 1, ok},
      '{make_req(irm_pkg::REQ_ASSIGN, 10, 20, 8'hab), 1, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 10, 0, 0), 0, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 19, 0, 0), 0, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 20, 0, 0), 0, ok},
      '{make_req(irm_pkg::REQ_ASSIGN, 15, 30, 8'hab), 1, ok},
      '{make_req(irm_pkg::REQ_ASSIGN, 0, 12, 8'h55), 1, ok},
      '{make_req(irm_pkg::REQ_ASSIGN, 32'sh80000000, 32'sh7fffffff, 8'hff), 1, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 32'sh80000000, 0, 0), 0, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 32'sh7fffffff, 0, 0), 0, ok},
      '{make_req(irm_pkg::REQ_ASSIGN, -1, 1, 8'h00), 1, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, -1, 0, 0), 0, ok},
      '{make_req(irm_pkg::REQ_LOOKUP, 0, 32'shffffffff, 8'hff), 0, ok}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_default(8'h00);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].known) send_known(directed_rows[i].req, directed_rows[i].result);
      else send_request(directed_rows[i].req);
    end

    // Fill the table to capacity so the refusal path is hit.
    for (int i = 0; i < CAP; i++)
      send_request(make_req(irm_pkg::REQ_ASSIGN, 1000 + 4 * i, 1002 + 4 * i,
                            (i & 1) ? 8'h33 : 8'h44));
    send_request(make_req(irm_pkg::REQ_ASSIGN, 5000, 5002, 8'h77));
    send_request(make_req(irm_pkg::REQ_ASSIGN, 6000, 6002, 8'h78));
    drain();

    // Default change takes effect below the first boundary at once.
    write_default(8'hff);
    send_request(make_req(irm_pkg::REQ_LOOKUP, 32'sh80000000, 0, 0));
    send_request(make_req(irm_pkg::REQ_LOOKUP, 32'sh80000000 + 1, 0, 0));

    // Random part, in phases with the default changed between them.
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        if (phase == 1 && i == 20) begin
          // Long receiver hold-off while requests keep coming.
          sink_mode = 2;
          sink_hold = 0;
          fork
            begin
              while (sink_hold < 600) @(posedge clk);
              sink_mode = 0;
            end
          join_none
        end
        if (phase == 2 && i == 0) begin
          sink_mode = 1;
          src_idle_on = 1'b0;
        end
        if (phase == 2 && i == 150) begin
          sink_mode = 0;
          src_idle_on = 1'b1;
        end
        if (i == 200) begin
          // Sender pauses until the block has returned everything.
          while (pending_results.size() != 0) @(posedge clk);
        end
        // Occasionally wipe most of the table so it does not stay full.
        if ($urandom_range(199) == 0)
          req = make_req(irm_pkg::REQ_ASSIGN, 32'sh80000000, 32'sh7fffffff, shadow_default);
        else
          req = random_req();
        send_request(req);
      end
      drain();
      case (phase)
        0: write_default(8'h5a);
        1: write_default(VB'($urandom()));
        default: write_default(8'h00);
      endcase
    end
    send_request(make_req(irm_pkg::REQ_LOOKUP, 32'sh80000000, 0, 0));

    drain();
    $display("Covered %0d results: %0d lookups, %0d empty and %0d full-table assigns,",
             result_count, lookup_count, empty_count, full_count);
    $display("with default register changes, a long output hold-off and random idling.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
